// ===== src/ehv_pkg.sv =====
// Package for the executable header validator: header field record, the
// snapshot handed from capture to check, and the format constants.
// No dependencies.
package ehv_pkg;

  localparam int KW           = 64;
  localparam int LEN_BITS_DEF = 32;

  localparam logic [7:0] MZ_0  = 8'h4d;
  localparam logic [7:0] MZ_1  = 8'h5a;
  localparam logic [7:0] ELF_0 = 8'h7f;
  localparam logic [7:0] ELF_1 = 8'h45;
  localparam logic [7:0] ELF_2 = 8'h4c;
  localparam logic [7:0] ELF_3 = 8'h46;

  localparam logic [3:0][7:0] PE_SIG = {8'h00, 8'h00, 8'h45, 8'h50};

  localparam logic [7:0]  PE_OFFSET_AT    = 8'h3c;
  localparam logic [7:0]  MIN_LEN         = 8'd64;
  localparam logic [7:0]  PE_SPAN         = 8'd88;
  localparam logic [7:0]  PE_COFF_END     = 8'd24;
  localparam logic [15:0] PE_MAGIC32      = 16'h010b;
  localparam logic [15:0] PE_MAGIC64      = 16'h020b;
  localparam logic [15:0] PE_MAX_SECTIONS = 16'd96;
  localparam logic [15:0] PE_OPT_MIN      = 16'd96;
  localparam logic [15:0] PE_OPT_MIN64    = 16'd112;
  localparam logic [5:0]  PE_SECTION_SIZE = 6'd40;

  localparam logic [7:0]  ELF_CLASS32    = 8'd1;
  localparam logic [7:0]  ELF_CLASS64    = 8'd2;
  localparam logic [7:0]  ELF_DATA_LSB   = 8'd1;
  localparam logic [7:0]  ELF_DATA_MSB   = 8'd2;
  localparam logic [7:0]  ELF_IDENT_VER  = 8'd1;
  localparam logic [15:0] ELF_ET_EXEC    = 16'd2;
  localparam logic [15:0] ELF_ET_DYN     = 16'd3;
  localparam logic [31:0] ELF_EV_CURRENT = 32'd1;
  localparam logic [15:0] ELF_HDR_SIZE32 = 16'd52;
  localparam logic [15:0] ELF_HDR_SIZE64 = 16'd64;
  localparam logic [15:0] ELF_PH_SIZE32  = 16'd32;
  localparam logic [15:0] ELF_PH_SIZE64  = 16'd56;

  typedef struct packed {
    logic [6:0][7:0] ident;
    logic [31:0]     pe_off;
    logic            sig_ok;
    logic [15:0]     coff_machine;
    logic [15:0]     section_count;
    logic [15:0]     optional_size;
    logic [15:0]     optional_magic;
    logic [31:0]     entry_rva;
    logic [31:0]     image_size;
    logic [31:0]     headers_size;
    logic [15:0]     elf_type;
    logic [15:0]     elf_machine;
    logic [31:0]     elf_version;
    logic [63:0]     ph_offset;
    logic [15:0]     elf_hsize;
    logic [15:0]     ph_esize;
    logic [15:0]     ph_count;
  } ehv_fields_t;

  typedef struct packed {
    ehv_fields_t     f;
    logic [KW-1:0]   total_len;
  } ehv_snap_t;

endpackage

// ===== src/ehv_capture.sv =====
// Byte position counter and header field capture for the header validator.
// Hands a snapshot of all fields and the total length to the check pipeline
// on the last byte. Depends on ehv_pkg.
module ehv_capture
  import ehv_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic [7:0] in_data_byte,
  input  logic      in_last_byte,
  input  logic      chk_ready,
  output logic      in_ready,
  output logic      push,
  output ehv_snap_t snap
);

  localparam logic [LEN_BITS-1:0] POS_MAX = '1;

  logic [LEN_BITS-1:0] pos_r, pos_nxt;
  ehv_fields_t         fld_r, fld_nxt;
  logic [KW-1:0]       pos_x, rel;
  logic [5:0]          p, hs_at, es_at, ec_at;
  logic [6:0]          r;
  logic                little, is64, acc;

  function automatic logic [63:0] put_lane(logic [63:0] fld, logic [2:0] k, logic [3:0] nb,
                                           logic [7:0] d, logic lsb);
    logic [5:0] sh;
    sh = lsb ? {k, 3'b000} : {3'(nb - 4'd1 - {1'b0, k}), 3'b000};
    return (fld & ~(64'hff << sh)) | (64'(d) << sh);
  endfunction

  assign in_ready = chk_ready;
  assign acc      = in_valid && in_ready;
  assign push     = acc && in_last_byte;

  assign pos_x  = KW'(pos_r);
  assign rel    = pos_x - KW'(fld_r.pe_off);
  assign p      = pos_r[5:0];
  assign r      = rel[6:0];
  assign little = fld_r.ident[5] == ELF_DATA_LSB;
  assign is64   = fld_r.ident[4] == ELF_CLASS64;
  assign hs_at  = is64 ? 6'd52 : 6'd40;
  assign es_at  = is64 ? 6'd54 : 6'd42;
  assign ec_at  = is64 ? 6'd56 : 6'd44;

  always_comb begin
    fld_nxt = fld_r;
    pos_nxt = pos_r;
    if (pos_r != POS_MAX) begin
      if (pos_x < KW'(7)) begin
        fld_nxt.ident[pos_r[2:0]] = in_data_byte;
      end
      if (pos_x >= KW'(PE_OFFSET_AT) && pos_x < KW'(PE_OFFSET_AT) + KW'(4)) begin
        fld_nxt.pe_off[{pos_r[1:0], 3'b000} +: 8] = in_data_byte;
      end
      if (pos_x < KW'(MIN_LEN)) begin
        if (p == 6'd16 || p == 6'd17) begin
          fld_nxt.elf_type = 16'(put_lane(64'(fld_r.elf_type), 3'(p - 6'd16), 4'd2,
                                          in_data_byte, little));
        end
        if (p == 6'd18 || p == 6'd19) begin
          fld_nxt.elf_machine = 16'(put_lane(64'(fld_r.elf_machine), 3'(p - 6'd18), 4'd2,
                                             in_data_byte, little));
        end
        if (p >= 6'd20 && p < 6'd24) begin
          fld_nxt.elf_version = 32'(put_lane(64'(fld_r.elf_version), 3'(p - 6'd20), 4'd4,
                                             in_data_byte, little));
        end
        if (is64 && p >= 6'd32 && p < 6'd40) begin
          fld_nxt.ph_offset = put_lane(fld_r.ph_offset, 3'(p - 6'd32), 4'd8,
                                       in_data_byte, little);
        end
        if (!is64 && p >= 6'd28 && p < 6'd32) begin
          fld_nxt.ph_offset = put_lane(fld_r.ph_offset, 3'(p - 6'd28), 4'd4,
                                       in_data_byte, little);
        end
        if (p == hs_at || p == hs_at + 6'd1) begin
          fld_nxt.elf_hsize = 16'(put_lane(64'(fld_r.elf_hsize), 3'(p - hs_at), 4'd2,
                                           in_data_byte, little));
        end
        if (p == es_at || p == es_at + 6'd1) begin
          fld_nxt.ph_esize = 16'(put_lane(64'(fld_r.ph_esize), 3'(p - es_at), 4'd2,
                                          in_data_byte, little));
        end
        if (p == ec_at || p == ec_at + 6'd1) begin
          fld_nxt.ph_count = 16'(put_lane(64'(fld_r.ph_count), 3'(p - ec_at), 4'd2,
                                          in_data_byte, little));
        end
      end else if (pos_x >= KW'(fld_r.pe_off) && rel < KW'(PE_SPAN)) begin
        if (r < 7'd4) begin
          if (r == 7'd0) begin
            fld_nxt.sig_ok = in_data_byte == PE_SIG[0];
          end else begin
            fld_nxt.sig_ok = fld_r.sig_ok && in_data_byte == PE_SIG[r[1:0]];
          end
        end else if (r < 7'd6) begin
          fld_nxt.coff_machine[{r[0], 3'b000} +: 8] = in_data_byte;
        end else if (r < 7'd8) begin
          fld_nxt.section_count[{r[0], 3'b000} +: 8] = in_data_byte;
        end else if (r == 7'd20 || r == 7'd21) begin
          fld_nxt.optional_size[{r[0], 3'b000} +: 8] = in_data_byte;
        end else if (r == 7'd24 || r == 7'd25) begin
          fld_nxt.optional_magic[{r[0], 3'b000} +: 8] = in_data_byte;
        end else if (r >= 7'd40 && r < 7'd44) begin
          fld_nxt.entry_rva[{r[1:0], 3'b000} +: 8] = in_data_byte;
        end else if (r >= 7'd80 && r < 7'd84) begin
          fld_nxt.image_size[{r[1:0], 3'b000} +: 8] = in_data_byte;
        end else if (r >= 7'd84) begin
          fld_nxt.headers_size[{r[1:0], 3'b000} +: 8] = in_data_byte;
        end
      end
      pos_nxt = pos_r + 1'b1;
    end
    snap.f         = fld_nxt;
    snap.total_len = KW'(pos_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      fld_r <= '0;
    end else if (acc) begin
      if (in_last_byte) begin
        pos_r <= '0;
        fld_r <= '0;
      end else begin
        pos_r <= pos_nxt;
        fld_r <= fld_nxt;
      end
    end
  end

`ifndef ASSERT_OFF
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> pos_r == '0 && fld_r == '0)
    else $error("position not cleared after last item");
  a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r == POS_MAX && !push |=> pos_r == POS_MAX)
    else $error("saturated position moved");
`endif

endmodule

// ===== src/ehv_check.sv =====
// Check pipeline of the header validator: snapshot register, product and
// partial-sum stage, final compares into the result register.
// Depends on ehv_pkg.
module ehv_check
  import ehv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ehv_snap_t snap,
  input  logic      out_ready,
  output logic      s1_ready,
  output logic      out_valid,
  output logic      out_header_valid
);

  ehv_snap_t     s1_r;
  logic          s1_v_r, s2_v_r, out_v_r, out_hv_r, out_hv_nxt;
  logic          s2_ready, out_free;
  ehv_fields_t   f;
  logic [KW-1:0] n;
  logic          is_pe, is_elf, is64, len_ok, pe_a_nxt, elf_a_nxt;
  logic [15:0]   hs, es_want;
  logic          pe_a_r, elf_a_r;
  logic [KW-1:0] n2_r;
  logic [34:0]   pe_part_r, pe_part_nxt, table_end;
  logic [21:0]   prod40_r, prod40_nxt;
  logic [31:0]   hdr_r, img_r, ent_r, elf_prod_r, elf_prod_nxt;
  logic [63:0]   room_r, room_nxt;

  assign out_free = !out_v_r || out_ready;
  assign s2_ready = !s2_v_r || out_free;
  assign s1_ready = !s1_v_r || s2_ready;

  assign f  = s1_r.f;
  assign n  = s1_r.total_len;

  always_comb begin
    is_pe   = f.ident[0] == MZ_0 && f.ident[1] == MZ_1;
    is_elf  = !is_pe && f.ident[0] == ELF_0 && f.ident[1] == ELF_1 &&
              f.ident[2] == ELF_2 && f.ident[3] == ELF_3;
    is64    = f.ident[4] == ELF_CLASS64;
    len_ok  = n >= KW'(MIN_LEN);
    hs      = is64 ? ELF_HDR_SIZE64 : ELF_HDR_SIZE32;
    es_want = is64 ? ELF_PH_SIZE64 : ELF_PH_SIZE32;

    pe_a_nxt = is_pe && len_ok && f.pe_off >= 32'(MIN_LEN) &&
               KW'(f.pe_off) + KW'(PE_COFF_END) <= n && f.sig_ok &&
               f.coff_machine != '0 && f.section_count != '0 &&
               f.section_count <= PE_MAX_SECTIONS && f.optional_size >= PE_OPT_MIN &&
               (f.optional_magic == PE_MAGIC32 ||
                (f.optional_magic == PE_MAGIC64 && f.optional_size >= PE_OPT_MIN64));
    pe_part_nxt = 35'(f.pe_off) + 35'(PE_COFF_END) + 35'(f.optional_size);
    prod40_nxt  = 22'(f.section_count) * 22'(PE_SECTION_SIZE);

    elf_a_nxt = is_elf && len_ok &&
                (f.ident[4] == ELF_CLASS32 || is64) &&
                (f.ident[5] == ELF_DATA_LSB || f.ident[5] == ELF_DATA_MSB) &&
                f.ident[6] == ELF_IDENT_VER &&
                (f.elf_type == ELF_ET_EXEC || f.elf_type == ELF_ET_DYN) &&
                f.elf_machine != '0 && f.elf_version == ELF_EV_CURRENT &&
                f.elf_hsize == hs && f.ph_esize == es_want && f.ph_count != '0 &&
                f.ph_offset >= 64'(hs) && 64'(f.ph_offset) <= 64'(n);
    elf_prod_nxt = 32'(f.ph_esize) * 32'(f.ph_count);
    room_nxt     = 64'(n) - f.ph_offset;
  end

  always_comb begin
    table_end  = pe_part_r + 35'(prod40_r);
    out_hv_nxt = (pe_a_r && KW'(table_end) <= n2_r && 35'(hdr_r) >= table_end &&
                  img_r >= hdr_r && ent_r < img_r) ||
                 (elf_a_r && 64'(elf_prod_r) <= room_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= push;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
      if (out_free) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && push) begin
      s1_r <= snap;
    end
    if (s2_ready && s1_v_r) begin
      pe_a_r     <= pe_a_nxt;
      elf_a_r    <= elf_a_nxt;
      n2_r       <= n;
      pe_part_r  <= pe_part_nxt;
      prod40_r   <= prod40_nxt;
      hdr_r      <= f.headers_size;
      img_r      <= f.image_size;
      ent_r      <= f.entry_rva;
      elf_prod_r <= elf_prod_nxt;
      room_r     <= room_nxt;
    end
    if (out_free && s2_v_r) begin
      out_hv_r <= out_hv_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_header_valid = out_hv_r;

`ifndef ASSERT_OFF
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !s2_ready |=> s2_v_r)
    else $error("stalled check stage lost its item");
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s2_v_r))
    else $error("result without an item in the check stage");
  a_s1_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(s1_v_r) |-> $past(push))
    else $error("snapshot stage filled without a last item");
`endif

endmodule

// ===== src/exe_header_validator.sv =====
// Top level of the PE / ELF executable header validator.
// Instantiates ehv_capture and ehv_check; depends on ehv_pkg.
//
// Takes one sample byte per cycle while in_ready is high, in address order,
// with in_last_byte on the final byte, and returns one item per sample:
// out_header_valid is 1 when the sample holds a well-formed PE or ELF header
// within its length. Bytes are accepted back to back at one per cycle unless
// the check pipeline stalls; a sample's result passes the snapshot register,
// product and partial-sum stage and final compare into the output register,
// and the next sample may start in the cycle after the last byte. The LEN_BITS
// wide position counter saturates; bytes beyond that point capture nothing.
module exe_header_validator
  import ehv_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_header_valid
);

  logic      chk_ready, push;
  ehv_snap_t snap;

  ehv_capture #(
    .LEN_BITS (LEN_BITS)
  ) u_capture (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .chk_ready    (chk_ready),
    .in_ready     (in_ready),
    .push         (push),
    .snap         (snap)
  );

  ehv_check u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .snap             (snap),
    .out_ready        (out_ready),
    .s1_ready         (chk_ready),
    .out_valid        (out_valid),
    .out_header_valid (out_header_valid)
  );

endmodule
